// ===== design/bdte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdte_pkg
// Shared types, constants and helper functions for the BCD date to epoch
// seconds converter: control word layout, program labels and calendar tables.
// ----------------------------------------------------------------------------
package bdte_pkg;

  localparam int unsigned PC_W   = 4;
  localparam int unsigned YEAR_W = 15;   // century * 100 + year, up to 16665
  localparam int unsigned CAL_W  = 12;   // calendar years 1970 to 2105

  typedef logic [PC_W-1:0] pc_t;

  localparam logic [CAL_W-1:0]  FIRST_YEAR = 12'd1970;
  localparam logic [YEAR_W-1:0] FIRST_FULL = 15'd1970;
  localparam logic [YEAR_W-1:0] LAST_FULL  = 15'd2105;
  localparam logic [CAL_W-1:0]  NONLEAP_CENTURY = 12'd2100;
  localparam logic [16:0]       SECS_DAY   = 17'd86400;
  localparam logic [11:0]       SECS_HOUR  = 12'd3600;
  localparam logic [5:0]        SECS_MIN   = 6'd60;
  localparam logic [3:0]        LAST_DONE_MONTH = 4'd11;

  // Program labels
  localparam pc_t PC_INIT  = 4'd0;
  localparam pc_t PC_YEARS = 4'd1;
  localparam pc_t PC_MONTH = 4'd2;
  localparam pc_t PC_LEAP  = 4'd3;
  localparam pc_t PC_DAY   = 4'd4;
  localparam pc_t PC_SCALE = 4'd5;
  localparam pc_t PC_HOUR  = 4'd6;
  localparam pc_t PC_MIN   = 4'd7;
  localparam pc_t PC_SEC   = 4'd8;
  localparam pc_t PC_FAIL  = 4'd9;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_ADD,
    ACC_MUL
  } acc_op_t;

  typedef enum logic [2:0] {
    OPD_YEAR,
    OPD_MONTH,
    OPD_LEAP,
    OPD_DAY,
    OPD_HOUR,
    OPD_MIN,
    OPD_SEC
  } opd_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_BAD,
    COND_YDONE,
    COND_MDONE
  } cond_t;

  // One control word. A looping word repeats its operation until the
  // condition holds, then falls through; otherwise the condition selects
  // a jump to target.
  typedef struct packed {
    acc_op_t acc_op;
    opd_t    opd;
    cond_t   cond;
    logic    loop;
    logic    cnt_init;
    logic    y_inc;
    logic    m_inc;
    logic    fin;
    logic    ok;
    pc_t     target;
  } ucode_t;

  localparam ucode_t CW_NOP = '{
    acc_op:   ACC_HOLD,
    opd:      OPD_SEC,
    cond:     COND_NEVER,
    loop:     1'b0,
    cnt_init: 1'b0,
    y_inc:    1'b0,
    m_inc:    1'b0,
    fin:      1'b0,
    ok:       1'b0,
    target:   PC_INIT
  };

  typedef struct packed {
    logic   capture;
    logic   exec;
    ucode_t cw;
  } dp_ctrl_t;

  typedef struct packed {
    logic bad;
    logic y_done;
    logic m_done;
  } dp_stat_t;

  function automatic logic [7:0] bcd_value(input logic [7:0] b);
    return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
  endfunction

  // Gregorian rule, valid across 1970 to 2105 where 2100 is the only
  // century year that is not a leap year
  function automatic logic is_leap(input logic [CAL_W-1:0] y);
    return (y[1:0] == 2'b00) && (y != NONLEAP_CENTURY);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd0:    len = 5'd31;
      4'd1:    len = 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== design/bdte_ucode_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdte_ucode_rom
// Read-only control store holding the conversion program, one word per step.
// ----------------------------------------------------------------------------
module bdte_ucode_rom (
  input  bdte_pkg::pc_t    pc,
  output bdte_pkg::ucode_t cw
);
  import bdte_pkg::*;

  always_comb begin
    cw = CW_NOP;
    unique case (pc)
      PC_INIT: begin
        cw.acc_op   = ACC_CLR;
        cw.cnt_init = 1'b1;
        cw.cond     = COND_BAD;
        cw.target   = PC_FAIL;
      end
      PC_YEARS: begin
        cw.acc_op = ACC_ADD;
        cw.opd    = OPD_YEAR;
        cw.y_inc  = 1'b1;
        cw.loop   = 1'b1;
        cw.cond   = COND_YDONE;
      end
      PC_MONTH: begin
        cw.acc_op = ACC_ADD;
        cw.opd    = OPD_MONTH;
        cw.m_inc  = 1'b1;
        cw.loop   = 1'b1;
        cw.cond   = COND_MDONE;
      end
      PC_LEAP: begin
        cw.acc_op = ACC_ADD;
        cw.opd    = OPD_LEAP;
      end
      PC_DAY: begin
        cw.acc_op = ACC_ADD;
        cw.opd    = OPD_DAY;
      end
      PC_SCALE: begin
        cw.acc_op = ACC_MUL;
      end
      PC_HOUR: begin
        cw.acc_op = ACC_ADD;
        cw.opd    = OPD_HOUR;
      end
      PC_MIN: begin
        cw.acc_op = ACC_ADD;
        cw.opd    = OPD_MIN;
      end
      PC_SEC: begin
        cw.acc_op = ACC_ADD;
        cw.opd    = OPD_SEC;
        cw.fin    = 1'b1;
        cw.ok     = 1'b1;
      end
      default: begin
        // out-of-range year, and any unused step: give zero, not valid
        cw.acc_op = ACC_CLR;
        cw.fin    = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/bdte_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdte_seq
// Step counter with conditional jumps; fetches control words from the
// program store and issues them to the datapath.
// ----------------------------------------------------------------------------
module bdte_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               out_busy,
  input  bdte_pkg::dp_stat_t stat,
  output bdte_pkg::dp_ctrl_t ctrl,
  output logic               run,
  output bdte_pkg::pc_t      pc
);
  import bdte_pkg::*;

  pc_t    pc_r, pc_nxt;
  logic   run_r, run_nxt;
  ucode_t cw;
  logic   cond_hit;
  logic   stall;
  logic   exec;

  bdte_ucode_rom u_rom (
    .pc (pc_r),
    .cw (cw)
  );

  always_comb begin
    case (cw.cond)
      COND_BAD:   cond_hit = stat.bad;
      COND_YDONE: cond_hit = stat.y_done;
      COND_MDONE: cond_hit = stat.m_done;
      default:    cond_hit = 1'b0;
    endcase
  end

  // hold the final step while the previous result is still unread
  assign stall = cw.fin && out_busy;
  assign exec  = run_r && !stall && !(cw.loop && cond_hit);

  always_comb begin
    pc_nxt  = pc_r;
    run_nxt = run_r;
    if (start) begin
      pc_nxt  = PC_INIT;
      run_nxt = 1'b1;
    end else if (run_r && !stall) begin
      if (cw.fin) begin
        run_nxt = 1'b0;
      end else if (cw.loop) begin
        pc_nxt = cond_hit ? pc_r + 1'b1 : pc_r;
      end else if (cond_hit) begin
        pc_nxt = cw.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= PC_INIT;
      run_r <= 1'b0;
    end else begin
      pc_r  <= pc_nxt;
      run_r <= run_nxt;
    end
  end

  assign ctrl.capture = start;
  assign ctrl.exec    = exec;
  assign ctrl.cw      = cw;
  assign run          = run_r;
  assign pc           = pc_r;

endmodule

// ===== design/bdte_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdte_datapath
// Decoded field registers, year and month counters, one accumulator with a
// shared adder and a day-to-seconds multiplier, and the result register.
// ----------------------------------------------------------------------------
module bdte_datapath (
  input  logic               clk,
  input  bdte_pkg::dp_ctrl_t ctrl,
  input  logic [7:0]         second_bcd,
  input  logic [7:0]         minute_bcd,
  input  logic [7:0]         hour_bcd,
  input  logic [7:0]         day_bcd,
  input  logic [7:0]         month_bcd,
  input  logic [7:0]         year_bcd,
  input  logic [7:0]         century_bcd,
  output bdte_pkg::dp_stat_t stat,
  output logic [31:0]        epoch_seconds,
  output logic               valid_res
);
  import bdte_pkg::*;

  logic [7:0]        sec_r, min_r, hour_r, mon_r, day_ofs_r;
  logic [YEAR_W-1:0] year_r;
  logic              bad_r;
  logic [3:0]        done_r;
  logic [CAL_W-1:0]  y_r;
  logic [3:0]        m_r;
  logic [31:0]       acc_r, acc_nxt;
  logic [31:0]       epoch_r;
  logic              vres_r;

  logic [7:0]        sec_b, min_b, hour_b, day_b, mon_b, yr_b, cent_b;
  logic [YEAR_W-1:0] year_full;
  logic [3:0]        done_cap;
  logic [31:0]       operand;
  logic [33:0]       day_prod;
  logic [19:0]       hour_secs;
  logic [13:0]       min_secs;
  logic              leap_day;

  assign sec_b  = bcd_value(second_bcd);
  assign min_b  = bcd_value(minute_bcd);
  assign hour_b = bcd_value(hour_bcd);
  assign day_b  = bcd_value(day_bcd);
  assign mon_b  = bcd_value(month_bcd);
  assign yr_b   = bcd_value(year_bcd);
  assign cent_b = bcd_value(century_bcd);

  assign year_full = YEAR_W'(cent_b) * YEAR_W'(100) + YEAR_W'(yr_b);

  // completed months: none for month zero, at most eleven
  always_comb begin
    if (mon_b == 8'd0) begin
      done_cap = 4'd0;
    end else if (mon_b > 8'd12) begin
      done_cap = LAST_DONE_MONTH;
    end else begin
      done_cap = 4'(mon_b - 8'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      sec_r     <= sec_b;
      min_r     <= min_b;
      hour_r    <= hour_b;
      mon_r     <= mon_b;
      day_ofs_r <= (day_b == 8'd0) ? 8'd0 : day_b - 8'd1;
      year_r    <= year_full;
      bad_r     <= (year_full < FIRST_FULL) || (year_full > LAST_FULL);
      done_r    <= done_cap;
    end
  end

  assign leap_day  = (mon_r > 8'd2) && is_leap(year_r[CAL_W-1:0]);
  assign day_prod  = 34'(acc_r[16:0]) * 34'(SECS_DAY);
  assign hour_secs = 20'(hour_r) * 20'(SECS_HOUR);
  assign min_secs  = 14'(min_r) * 14'(SECS_MIN);

  always_comb begin
    case (ctrl.cw.opd)
      OPD_YEAR:  operand = is_leap(y_r) ? 32'd366 : 32'd365;
      OPD_MONTH: operand = 32'(month_len(m_r));
      OPD_LEAP:  operand = 32'(leap_day);
      OPD_DAY:   operand = 32'(day_ofs_r);
      OPD_HOUR:  operand = 32'(hour_secs);
      OPD_MIN:   operand = 32'(min_secs);
      default:   operand = 32'(sec_r);
    endcase
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.exec) begin
      case (ctrl.cw.acc_op)
        ACC_CLR: acc_nxt = 32'd0;
        ACC_ADD: acc_nxt = acc_r + operand;
        ACC_MUL: acc_nxt = day_prod[31:0];
        default: acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (ctrl.exec && ctrl.cw.cnt_init) begin
      y_r <= FIRST_YEAR;
      m_r <= 4'd0;
    end else begin
      if (ctrl.exec && ctrl.cw.y_inc) begin
        y_r <= y_r + 1'b1;
      end
      if (ctrl.exec && ctrl.cw.m_inc) begin
        m_r <= m_r + 1'b1;
      end
    end
    if (ctrl.exec && ctrl.cw.fin) begin
      epoch_r <= acc_nxt;
      vres_r  <= ctrl.cw.ok;
    end
  end

  assign stat.bad    = bad_r;
  assign stat.y_done = (YEAR_W'(y_r) == year_r);
  assign stat.m_done = (m_r == done_r);

  assign epoch_seconds = epoch_r;
  assign valid_res     = vres_r;

endmodule

// ===== design/bcd_datetime_to_epoch_seconds_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_datetime_to_epoch_seconds_top
// Converts an RTC snapshot in BCD to seconds since 1970-01-01 00:00:00.
// ----------------------------------------------------------------------------
// One transaction at a time. An accepted snapshot runs a short microprogram
// on a single accumulator. For a year within 1970 to 2105 the program loops
// once per whole year since 1970 and once per completed month; a year
// outside that range jumps from the first step straight to the fail step.
// The year loop adds one year length per cycle. The result then sits in an
// output register, and the next snapshot is taken as soon as the program has
// finished, even while that result is still unread.
module bcd_datetime_to_epoch_seconds_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_second_bcd,
  input  logic [7:0]  in_minute_bcd,
  input  logic [7:0]  in_hour_bcd,
  input  logic [7:0]  in_day_bcd,
  input  logic [7:0]  in_month_bcd,
  input  logic [7:0]  in_year_bcd,
  input  logic [7:0]  in_century_bcd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_epoch_seconds,
  output logic        out_valid_res
);
  import bdte_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;
  logic     run;
  pc_t      pc;
  logic     start;
  logic     out_valid_r, out_valid_nxt;

  assign in_ready = !run;
  assign start    = in_valid && in_ready;

  bdte_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_busy (out_valid_r && !out_ready),
    .stat     (stat),
    .ctrl     (ctrl),
    .run      (run),
    .pc       (pc)
  );

  bdte_datapath u_dp (
    .clk           (clk),
    .ctrl          (ctrl),
    .second_bcd    (in_second_bcd),
    .minute_bcd    (in_minute_bcd),
    .hour_bcd      (in_hour_bcd),
    .day_bcd       (in_day_bcd),
    .month_bcd     (in_month_bcd),
    .year_bcd      (in_year_bcd),
    .century_bcd   (in_century_bcd),
    .stat          (stat),
    .epoch_seconds (out_epoch_seconds),
    .valid_res     (out_valid_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.exec && ctrl.cw.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (run && pc == PC_INIT))
    else $error("accepted snapshot did not start the program");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_valid_res || out_epoch_seconds == 32'd0))
    else $error("invalid result carries non-zero seconds");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.exec && ctrl.cw.fin) |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before it was taken");

  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    run |-> (pc <= PC_FAIL))
    else $error("step counter left the program");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the BCD RTC snapshot to epoch seconds converter.
// A queue-fed driver offers snapshots in bursts and a monitor checks every
// result, field by field, against a calendar computed in the bench.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned RUN_LIMIT   = 1000000;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned LONG_HOLD   = 800;
  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    bit [7:0] second;
    bit [7:0] minute;
    bit [7:0] hour;
    bit [7:0] day;
    bit [7:0] month;
    bit [7:0] year;
    bit [7:0] century;
  } rtc_snap_t;

  typedef struct packed {
    bit [31:0] seconds;
    bit        in_range;
  } epoch_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_second_bcd = 8'h00;
  logic [7:0]  in_minute_bcd = 8'h00;
  logic [7:0]  in_hour_bcd = 8'h00;
  logic [7:0]  in_day_bcd = 8'h00;
  logic [7:0]  in_month_bcd = 8'h00;
  logic [7:0]  in_year_bcd = 8'h00;
  logic [7:0]  in_century_bcd = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_epoch_seconds;
  logic        out_valid_res;

  rtc_snap_t   pending_snaps[$];
  epoch_res_t  epoch_expected[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned snaps_sent = 0;
  int unsigned in_range_seen = 0;
  int unsigned out_of_range_seen = 0;
  bit          long_hold_req = 1'b0;

  bcd_datetime_to_epoch_seconds_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_second_bcd     (in_second_bcd),
    .in_minute_bcd     (in_minute_bcd),
    .in_hour_bcd       (in_hour_bcd),
    .in_day_bcd        (in_day_bcd),
    .in_month_bcd      (in_month_bcd),
    .in_year_bcd       (in_year_bcd),
    .in_century_bcd    (in_century_bcd),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_epoch_seconds (out_epoch_seconds),
    .out_valid_res     (out_valid_res)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned bcd_dec(bit [7:0] b);
    return b[7:4] * 10 + b[3:0];
  endfunction

  function automatic bit [7:0] to_bcd(int unsigned v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic epoch_res_t predict_epoch(rtc_snap_t s);
    epoch_res_t  r;
    int unsigned full_year;
    int unsigned mon;
    int unsigned done;
    int unsigned dom;
    int unsigned y;
    bit [31:0]   days;
    full_year = bcd_dec(s.century) * 100 + bcd_dec(s.year);
    mon = bcd_dec(s.month);
    dom = bcd_dec(s.day);
    days = 0;
    r.seconds = 0;
    r.in_range = 1'b0;
    if (full_year < 1970 || full_year > 2105) begin
      return r;
    end
    for (y = 1970; y < full_year; y++) begin
      days += leap_year(y) ? 366 : 365;
    end
    // Completed months saturate at eleven; month zero counts none
    done = (mon == 0) ? 0 : mon - 1;
    if (done > 11) begin
      done = 11;
    end
    for (y = 0; y < done; y++) begin
      days += MONTH_DAYS[y];
    end
    if (mon > 2 && leap_year(full_year)) begin
      days += 1;
    end
    days += (dom == 0) ? 0 : dom - 1;
    r.seconds = days * 32'd86400 + 32'(bcd_dec(s.hour)) * 32'd3600
              + 32'(bcd_dec(s.minute)) * 32'd60 + 32'(bcd_dec(s.second));
    r.in_range = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string what, bit [31:0] got, bit [31:0] want);
    $display("[%0t] %s: got 0x%08h, want 0x%08h", $time, what, got, want);
    error_count++;
  endtask

  task automatic push_snap(bit [7:0] cent, bit [7:0] yr, bit [7:0] mon, bit [7:0] dom,
                           bit [7:0] hr, bit [7:0] mi, bit [7:0] se);
    rtc_snap_t s;
    s = '{second: se, minute: mi, hour: hr, day: dom, month: mon, year: yr, century: cent};
    pending_snaps.push_back(s);
  endtask

  task automatic push_random;
    int unsigned full_year;
    int unsigned pick;
    rtc_snap_t   s;
    pick = $urandom_range(0, 99);
    full_year = $urandom_range(1970, 2105);
    s.century = to_bcd(full_year / 100);
    s.year    = to_bcd(full_year % 100);
    s.month   = to_bcd($urandom_range(1, 12));
    s.day     = to_bcd($urandom_range(1, 31));
    s.hour    = to_bcd($urandom_range(0, 23));
    s.minute  = to_bcd($urandom_range(0, 59));
    s.second  = to_bcd($urandom_range(0, 59));
    if (pick >= 85) begin
      s = rtc_snap_t'({$urandom(), $urandom()});
    end else if (pick >= 70) begin
      // keep the year in range, scramble the rest
      s.month  = 8'($urandom());
      s.day    = 8'($urandom());
      s.hour   = 8'($urandom());
      s.minute = 8'($urandom());
      s.second = 8'($urandom());
    end
    pending_snaps.push_back(s);
  endtask

  task automatic wait_drained;
    do begin
      @(negedge clk);
    end while (pending_snaps.size() != 0 || in_valid || epoch_expected.size() != 0);
  endtask

  // Driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    int unsigned burst_left;
    int unsigned gap_left;
    rtc_snap_t   s;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && in_ready) begin
        s = '{second: in_second_bcd, minute: in_minute_bcd, hour: in_hour_bcd,
              day: in_day_bcd, month: in_month_bcd, year: in_year_bcd,
              century: in_century_bcd};
        epoch_expected.push_back(predict_epoch(s));
        snaps_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_snaps.size() != 0) begin
          s = pending_snaps.pop_front();
          in_second_bcd  <= s.second;
          in_minute_bcd  <= s.minute;
          in_hour_bcd    <= s.hour;
          in_day_bcd     <= s.day;
          in_month_bcd   <= s.month;
          in_year_bcd    <= s.year;
          in_century_bcd <= s.century;
          in_valid       <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
              1:       gap_left = $urandom_range(1, 10);
              2:       gap_left = $urandom_range(20, 170);
              default: gap_left = 0;
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern in phases, plus one long hold on request
  always @(posedge clk) begin
    int unsigned hold_left;
    int unsigned phase_left;
    int unsigned rx_mode;
    bit          hold_done;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      hold_left  = 0;
      phase_left = 0;
      rx_mode    = 0;
      hold_done  = 1'b0;
    end else begin
      if (long_hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(16, 200);
        rx_mode    = $urandom_range(0, 2);
      end else begin
        phase_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    epoch_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (epoch_expected.size() == 0) begin
        report_mismatch("result with nothing expected", out_epoch_seconds, 32'd0);
      end else begin
        want = epoch_expected.pop_front();
        if (out_epoch_seconds !== want.seconds) begin
          report_mismatch("epoch_seconds", out_epoch_seconds, want.seconds);
        end
        if (out_valid_res !== want.in_range) begin
          report_mismatch("valid_res", 32'(out_valid_res), 32'(want.in_range));
        end
        if (want.in_range) begin
          in_range_seen++;
        end else begin
          out_of_range_seen++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, epoch_expected.size());
      $display("bcd_datetime_to_epoch_seconds_top: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_snap(8'h19, 8'h70, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00);  // epoch origin
    push_snap(8'h21, 8'h05, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59);  // last valid second
    push_snap(8'h19, 8'h69, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59);  // just below range
    push_snap(8'h21, 8'h06, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00);  // just above range
    push_snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_snap(8'h21, 8'h05, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);  // oversized fields, wraps
    push_snap(8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);  // month and day zero
    push_snap(8'h20, 8'h01, 8'h13, 8'h15, 8'h10, 8'h20, 8'h30);  // month thirteen
    push_snap(8'h20, 8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00);  // leap century
    push_snap(8'h21, 8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00);  // non-leap century
    push_snap(8'h20, 8'h24, 8'h02, 8'h29, 8'h12, 8'h00, 8'h00);
    push_snap(8'h19, 8'h72, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00);
    push_snap(8'h19, 8'h7A, 8'h0A, 8'h1F, 8'hA0, 8'h0F, 8'h5A);  // non-BCD digits
    push_snap(8'h1A, 8'h00, 8'h06, 8'h15, 8'h08, 8'h30, 8'h00);  // century digit A
    push_snap(8'h1F, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00);
    push_snap(8'h20, 8'h38, 8'h01, 8'h19, 8'h03, 8'h14, 8'h08);  // bit 31 boundary
    push_snap(8'h20, 8'hA5, 8'h12, 8'h31, 8'h00, 8'h00, 8'h00);  // decodes to 2105
    push_snap(8'h20, 8'hA6, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00);  // decodes to 2106
    push_snap(8'h19, 8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59);
    push_snap(8'h19, 8'h6A, 8'h01, 8'h01, 8'h00, 8'h00, 8'h01);  // decodes to 1970
    push_snap(8'h21, 8'h05, 8'h12, 8'h00, 8'h00, 8'h00, 8'h00);
    // hold new snapshots back until every result is in
    wait_drained();

    // long receiver hold while the sender keeps offering
    long_hold_req = 1'b1;
    repeat (30) push_random();
    wait_drained();

    repeat (185) push_random();
    wait_drained();
    repeat (185) push_random();
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (epoch_expected.size() != 0) begin
      report_mismatch("results never delivered", epoch_expected.size(), 32'd0);
    end
    $display("Converted %0d snapshots in %0d cycles: %0d in range, %0d out of range,",
             snaps_sent, cycle_count, in_range_seen, out_of_range_seen);
    $display("with burst gaps, receiver stalls and one long output hold; %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("bcd_datetime_to_epoch_seconds_top: match");
    end else begin
      $display("bcd_datetime_to_epoch_seconds_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== bcd_datetime_to_epoch_seconds_top.f =====
design/bdte_pkg.sv
design/bdte_ucode_rom.sv
design/bdte_seq.sv
design/bdte_datapath.sv
design/bcd_datetime_to_epoch_seconds_top.sv
tb/tb_top.sv
